// ===== design/call_blacklist_scanner_core_macros.svh =====
// assertion macros shared by the blacklist scanner rtl
`ifndef CALL_BLACKLIST_SCANNER_CORE_MACROS_SVH
`define CALL_BLACKLIST_SCANNER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define CBS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");

// next-cycle implication, checked out of reset
`define CBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");

`endif

// ===== design/cbs_pkg.sv =====
// shared types, name rom and helpers for the blacklist scanner
package cbs_pkg;

    localparam int ROM_NAMES = 31;
    localparam int OUT_DEPTH = 4;

    typedef logic [63:0] t_name;

    // names right-justified as string literals, at most eight characters
    localparam t_name ROM_TEXT [ROM_NAMES] = '{
        "strcpy", "strcat", "strncpy", "strncat", "sprintf", "vsprintf",
        "gets", "fgets", "alloca", "memcpy", "memset", "fopen", "freopen",
        "fclose", "fread", "fwrite", "fscanf", "fprintf", "system", "popen",
        "pclose", "execl", "execv", "execle", "execve", "socket", "connect",
        "bind", "listen", "accept", "offsetof"
    };

    // per-cell control for one accepted byte
    typedef struct packed {
        logic clear;    // end of text, mask back to all ones
        logic ext;      // compare this byte at the current position
        logic restart;  // identifier starts here, mask starts full
    } t_cell_ctl;

    typedef struct packed {
        logic        kind;
        logic [15:0] line;
        logic [15:0] col;
        logic [4:0]  entry;
        logic [15:0] total;
        logic        closing;
    } t_result;

    function automatic int name_len(input int e);
        int    n;
        t_name raw;
        n = 0;
        raw = '0;
        if (e < ROM_NAMES) begin
            raw = ROM_TEXT[e];
        end
        for (int b = 0; b < 8; b++) begin
            if (raw[8*b +: 8] != 8'h00) begin
                n++;
            end
        end
        return n;
    endfunction

    // first character in the low byte
    function automatic t_name name_bytes(input int e);
        t_name raw;
        t_name res;
        int    n;
        raw = '0;
        res = '0;
        n = name_len(e);
        if (e < ROM_NAMES) begin
            raw = ROM_TEXT[e];
        end
        for (int p = 0; p < 8; p++) begin
            if (p < n) begin
                res[8*p +: 8] = raw[8*(n-1-p) +: 8];
            end
        end
        return res;
    endfunction

endpackage

// ===== design/cbs_cell.sv =====
// one rom entry: running match bit and its link in the priority chain
module cbs_cell #(
    parameter int ENTRY = 0,
    parameter int LEN_W = 7,
    parameter int IDX_W = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cbs_pkg::t_cell_ctl    i_ctl,
    input  logic [7:0]            i_char,
    input  logic [LEN_W-1:0]      i_pos,
    input  logic [LEN_W-1:0]      i_len,
    input  logic                  i_found,
    input  logic [IDX_W-1:0]      i_idx,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_idx
);
    import cbs_pkg::*;

    localparam t_name NAME = name_bytes(ENTRY);
    localparam int    NLEN = name_len(ENTRY);

    logic r_match;
    logic n_match;
    logic keep;
    logic mine;

    assign keep = (i_pos < LEN_W'(NLEN)) && (NAME[{i_pos[2:0], 3'b000} +: 8] == i_char);

    always_comb begin
        n_match = r_match;
        if (i_ctl.clear) begin
            n_match = 1'b1;
        end else if (i_ctl.ext) begin
            n_match = (i_ctl.restart | r_match) & keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b1;
        end else begin
            r_match <= n_match;
        end
    end

    // lowest entry wins
    assign mine    = r_match && (NLEN != 0) && (i_len == LEN_W'(NLEN));
    assign o_found = i_found | mine;
    assign o_idx   = i_found ? i_idx : IDX_W'(ENTRY);

endmodule

// ===== design/cbs_out_fifo.sv =====
// small result queue, two writes and one read per cycle
module cbs_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push0,
    input  cbs_pkg::t_result  i_data0,
    input  logic              i_push1,
    input  cbs_pkg::t_result  i_data1,
    output logic              o_room_two,
    output logic              o_valid,
    input  logic              i_ready,
    output cbs_pkg::t_result  o_data
);
    import cbs_pkg::*;

    localparam int PTR_W = $clog2(OUT_DEPTH);

    t_result          r_mem [OUT_DEPTH];
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W:0]   r_cnt, n_cnt;
    logic             pop;

    assign pop        = (r_cnt != '0) && i_ready;
    assign o_valid    = (r_cnt != '0);
    assign o_data     = r_mem[r_rd];
    assign o_room_two = (r_cnt <= (PTR_W+1)'(OUT_DEPTH - 2));

    always_comb begin
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_wr  = r_wr + PTR_W'(i_push0) + PTR_W'(i_push1);
        n_cnt = r_cnt + (PTR_W+1)'(i_push0) + (PTR_W+1)'(i_push1) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[r_wr + 1'b1] <= i_data1;
        end
    end

endmodule

// ===== design/call_blacklist_scanner_core.sv =====
// top level of the blacklisted call scanner
// The scanner takes one text byte per clock while s_tready is high and
// reports calls to names in a fixed rom of banned functions. Each accepted
// byte is fully handled in the cycle it is taken: the tokenizer state moves
// on and every rom entry's cell compares the byte at the current identifier
// position, so the next byte can be taken in the next cycle. Results
// land in a four-deep queue and are registered there before they appear on
// the master side; the queue sends one result per clock while m_tready is
// high, so a final byte that closes a call and ends the text yields two
// results, violation then summary. s_tready is high while the queue has two
// free slots, which keeps one byte per cycle going as long as the master
// side takes results. There is no clearing pass after reset. The enable
// register may be written at any idle moment and does not disturb scan state.
module call_blacklist_scanner_core #(
    parameter int MAX_IDENT_LEN = 64,
    parameter int ENTRY_COUNT   = 31,
    parameter int COUNTER_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // text stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // text_byte
    input  logic        i_s_tlast,   // end_of_text
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // line_number, column_number, entry_index,
                                     // violation_total, zero fill
    output logic        o_m_tuser,   // kind
    output logic        o_m_tlast,   // closing
    // enable register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data   // scan_enable
);
    import cbs_pkg::*;
    `include "call_blacklist_scanner_core_macros.svh"

    localparam int LEN_W = $clog2(MAX_IDENT_LEN + 1);
    localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int CNT_W = COUNTER_BITS;

    typedef enum logic [1:0] {
        MODE_OUT   = 2'd0,
        MODE_IDENT = 2'd1,
        MODE_WAIT  = 2'd2
    } t_mode;

    // scan state
    t_mode             r_mode, n_mode;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [IDX_W-1:0]  r_pending, n_pending;
    logic [CNT_W-1:0]  r_sline, n_sline;
    logic [CNT_W-1:0]  r_scol, n_scol;
    logic [CNT_W-1:0]  r_line, n_line;
    logic [CNT_W-1:0]  r_col, n_col;
    logic [CNT_W-1:0]  r_found, n_found;
    logic              r_enable;

    logic              in_acc;
    logic              room_two;
    logic [7:0]        ch;
    logic              letter, alnum, blank, paren, newline;
    t_mode             mode_in, mode_mid;
    t_cell_ctl         ctl_c, ctl;
    logic [LEN_W-1:0]  pos;
    logic              viol;
    logic [IDX_W-1:0]  viol_idx;
    logic              viol_en;
    logic [CNT_W-1:0]  found_rep;
    logic              hit_ok;
    t_result           vio_res, sum_res, q_data;

    // priority chain through the cells
    logic              chain_found [ENTRY_COUNT+1];
    logic [IDX_W-1:0]  chain_idx   [ENTRY_COUNT+1];

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] clamp16(input logic [CNT_W-1:0] v);
        return ((CNT_W > 16) && ((v >> 16) != '0)) ? 16'hFFFF : 16'(v);
    endfunction

    assign in_acc      = i_s_tvalid & o_s_tready;
    assign o_s_tready  = room_two;
    assign o_cfg_ready = 1'b1;
    assign ch          = i_s_tdata;

    // character classes
    assign letter  = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A))
                     || (ch == 8'h5F);
    assign alnum   = letter || ((ch >= 8'h30) && (ch <= 8'h39));
    assign blank   = (ch == 8'h20) || (ch == 8'h09);
    assign paren   = (ch == 8'h28);
    assign newline = (ch == 8'h0A);

    // the identifier only counts if it is short enough to have been tracked
    assign hit_ok = chain_found[ENTRY_COUNT] && (r_len != '0)
                    && (r_len < LEN_W'(MAX_IDENT_LEN));

    assign chain_found[0] = 1'b0;
    assign chain_idx[0]   = '0;

    for (genvar e = 0; e < ENTRY_COUNT; e++) begin : g_cell
        cbs_cell #(
            .ENTRY (e),
            .LEN_W (LEN_W),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_char  (ch),
            .i_pos   (pos),
            .i_len   (r_len),
            .i_found (chain_found[e]),
            .i_idx   (chain_idx[e]),
            .o_found (chain_found[e+1]),
            .o_idx   (chain_idx[e+1])
        );
    end

    always_comb begin
        case (r_mode)
            MODE_IDENT: mode_in = MODE_IDENT;
            MODE_WAIT:  mode_in = MODE_WAIT;
            default:    mode_in = MODE_OUT;
        endcase

        n_mode    = mode_in;
        n_len     = r_len;
        n_pending = r_pending;
        n_sline   = r_sline;
        n_scol    = r_scol;
        n_line    = r_line;
        n_col     = r_col;
        n_found   = r_found;
        ctl_c     = '0;
        pos       = r_len;
        viol      = 1'b0;
        viol_idx  = '0;
        mode_mid  = mode_in;

        if ((mode_in == MODE_IDENT) && alnum) begin
            // identifier goes on; past the length limit it can no longer match
            if (r_len < LEN_W'(MAX_IDENT_LEN)) begin
                ctl_c.ext = 1'b1;
                n_len     = r_len + 1'b1;
            end
            n_col = sat_inc(r_col);
        end else begin
            if (mode_in == MODE_IDENT) begin
                mode_mid = MODE_OUT;
                if (hit_ok) begin
                    if (paren) begin
                        viol     = 1'b1;
                        viol_idx = chain_idx[ENTRY_COUNT];
                    end else if (blank) begin
                        n_pending = chain_idx[ENTRY_COUNT];
                        mode_mid  = MODE_WAIT;
                    end
                end
            end else if (mode_in == MODE_WAIT) begin
                if (paren) begin
                    viol     = 1'b1;
                    viol_idx = r_pending;
                    mode_mid = MODE_OUT;
                end else if (!blank) begin
                    mode_mid = MODE_OUT;
                end
            end
            n_mode = mode_mid;

            if ((mode_mid == MODE_OUT) && letter) begin
                // new identifier, remember where it starts
                n_sline       = r_line;
                n_scol        = r_col;
                n_len         = LEN_W'(1);
                pos           = '0;
                ctl_c.ext     = 1'b1;
                ctl_c.restart = 1'b1;
                n_mode        = MODE_IDENT;
                n_col         = sat_inc(r_col);
            end else if (newline) begin
                n_line = sat_inc(r_line);
                n_col  = CNT_W'(1);
            end else begin
                n_col = sat_inc(r_col);
            end
        end

        viol_en   = viol & r_enable;
        found_rep = viol_en ? sat_inc(r_found) : r_found;
        n_found   = found_rep;

        if (i_s_tlast) begin
            // end of text: counters and tokenizer start over
            ctl_c.clear = 1'b1;
            n_mode      = MODE_OUT;
            n_len       = '0;
            n_pending   = '0;
            n_sline     = CNT_W'(1);
            n_scol      = CNT_W'(1);
            n_line      = CNT_W'(1);
            n_col       = CNT_W'(1);
            n_found     = '0;
        end

        ctl = in_acc ? ctl_c : '0;

        vio_res.kind    = 1'b0;
        vio_res.line    = clamp16(r_sline);
        vio_res.col     = clamp16(r_scol);
        vio_res.entry   = 5'(viol_idx);
        vio_res.total   = clamp16(found_rep);
        vio_res.closing = ~i_s_tlast;

        sum_res.kind    = 1'b1;
        sum_res.line    = '0;
        sum_res.col     = '0;
        sum_res.entry   = '0;
        sum_res.total   = clamp16(found_rep);
        sum_res.closing = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_OUT;
            r_len     <= '0;
            r_pending <= '0;
            r_sline   <= CNT_W'(1);
            r_scol    <= CNT_W'(1);
            r_line    <= CNT_W'(1);
            r_col     <= CNT_W'(1);
            r_found   <= '0;
            r_enable  <= 1'b1;
        end else begin
            if (in_acc) begin
                r_mode    <= n_mode;
                r_len     <= n_len;
                r_pending <= n_pending;
                r_sline   <= n_sline;
                r_scol    <= n_scol;
                r_line    <= n_line;
                r_col     <= n_col;
                r_found   <= n_found;
            end
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
        end
    end

    // violation first, summary behind it when both come from one byte
    cbs_out_fifo u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push0    (in_acc & (viol_en | i_s_tlast)),
        .i_data0    (viol_en ? vio_res : sum_res),
        .i_push1    (in_acc & viol_en & i_s_tlast),
        .i_data1    (sum_res),
        .o_room_two (room_two),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_data     (q_data)
    );

    assign o_m_tdata = {3'b000, q_data.total, q_data.entry, q_data.col, q_data.line};
    assign o_m_tuser = q_data.kind;
    assign o_m_tlast = q_data.closing;

    `CBS_ASSERT_NOW(a_summary_closes, o_m_tvalid && o_m_tuser, o_m_tlast)
    `CBS_ASSERT_NEXT(a_eot_restarts, in_acc && i_s_tlast,
        (r_found == '0) && (r_line == CNT_W'(1)) && (r_mode == MODE_OUT))
    `CBS_ASSERT_NOW(a_wait_has_ident, r_mode == MODE_WAIT, r_len != '0)

endmodule
